FILE: design/digf_pkg.sv
// shared constants and sequencer state type for the fixed-point digamma block
`timescale 1ns / 1ps

package digf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QB        = 32;
    localparam int ACC_W     = 56;
    localparam int QUOT_W    = QB + FRAC_BITS + 1;

    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] C12_Q32  = 32'd357913941;
    localparam logic [31:0] C120_Q32 = 32'd35791394;
    localparam logic [31:0] C252_Q32 = 32'd17043521;

    localparam logic [31:0] THR_Y = 32'(12) << FRAC_BITS;
    localparam logic [31:0] ONE_Y = 32'(1) << FRAC_BITS;

    localparam logic [47:0] OUT_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MINM = 48'h8000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_REC,
        ST_WAIT_REC,
        ST_DIV_R,
        ST_WAIT_R,
        ST_NORM,
        ST_SQ,
        ST_LN_I,
        ST_LN_F,
        ST_R2,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_T5,
        ST_ACC1,
        ST_ACC2,
        ST_ACC3,
        ST_ROUND,
        ST_DONE
    } t_state;

endpackage

FILE: design/digf_if.sv
// stream interfaces for the argument and result channels
`timescale 1ns / 1ps

interface digf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_value;
    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

interface digf_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] psi_value;
    logic               invalid_arg;
    logic               saturated;
    modport source (output valid, output psi_value, output invalid_arg, output saturated,
                    input ready);
    modport sink   (input valid, input psi_value, input invalid_arg, input saturated,
                    output ready);
endinterface

FILE: design/digf_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module digf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [digf_pkg::QUOT_W-1:0]   i_dividend,
    input  logic [31:0]                   i_divisor,
    output logic                          o_done,
    output logic [digf_pkg::QUOT_W-1:0]   o_quot
);

    logic [31:0]                 r_rem;
    logic [31:0]                 r_div;
    logic [digf_pkg::QUOT_W-1:0] r_quot;
    logic [5:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [32:0]                 trial;
    logic                        fits;

    assign trial  = {r_rem, r_quot[digf_pkg::QUOT_W-1]};
    assign fits   = trial >= {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quot <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= fits ? 32'(trial - {1'b0, r_div}) : trial[31:0];
                r_quot <= {r_quot[digf_pkg::QUOT_W-2:0], fits};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(digf_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/digamma_fixed_point.sv
// fixed-point digamma: recurrence, logarithm and asymptotic series on shared units
// usage
//  - i_in carries one unsigned q16.16 argument per transaction (valid/ready)
//  - o_out carries psi in signed q31.16 plus invalid and saturation flags
//  - one argument in flight: i_in.ready is high only while the sequencer idles
//  - zero argument answers in the cycle after acceptance with invalid set
//  - each reciprocal runs on the bit-serial divider; below 12 the recurrence
//    needs ceil(12 - x) of them plus the final one
//  - log: up to 12 normalising shifts then 32 squaring rounds on the multiplier
//  - then the series terms and the final sum with rounding and saturation
//  - the next argument is taken once the result has left
//  - the result holds on o_out until o_out.ready; no new argument is taken meanwhile
//  - synchronous active-low reset returns the sequencer to idle and drops o_out.valid
`timescale 1ns / 1ps

module digamma_fixed_point (
    input  logic       i_clk,
    input  logic       i_rst_n,
    digf_in_if.sink    i_in,
    digf_out_if.source o_out
);

    digf_pkg::t_state r_state, n_state;

    logic [31:0]                   r_y;
    logic [31:0]                   r_r;
    logic [30:0]                   r_m;
    logic [31:0]                   r_frac;
    logic [3:0]                    r_k;
    logic [4:0]                    r_cnt;
    logic [36:0]                   r_lnv;
    logic [31:0]                   r_r2;
    logic [31:0]                   r_t;
    logic signed [digf_pkg::ACC_W-1:0] r_acc;
    logic signed [47:0]            r_psi;
    logic                          r_inv;
    logic                          r_sat;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] prod_rnd;

    // divider
    logic                          div_start;
    logic                          div_done;
    logic [digf_pkg::QUOT_W-1:0]   div_quot;
    logic [digf_pkg::QUOT_W-1:0]   dividend;

    // rounding of the final sum
    logic [digf_pkg::ACC_W-1:0]    mag;
    logic [digf_pkg::ACC_W-1:0]    mag_rnd;
    logic [47:0]                   q48;

    assign prod     = mul_a * mul_b;
    assign prod_rnd = prod[63:32] + {31'd0, prod[31]};
    assign dividend = (digf_pkg::QUOT_W'(1) << (digf_pkg::QB + digf_pkg::FRAC_BITS))
                      + digf_pkg::QUOT_W'(r_y >> 1);

    assign mag     = r_acc[digf_pkg::ACC_W-1] ? digf_pkg::ACC_W'(-r_acc)
                                              : digf_pkg::ACC_W'(r_acc);
    assign mag_rnd = mag + digf_pkg::ACC_W'(1 << (digf_pkg::QB - digf_pkg::FRAC_BITS - 1));
    assign q48     = 48'(mag_rnd >> (digf_pkg::QB - digf_pkg::FRAC_BITS));

    digf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_y),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            digf_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.x_value == 32'd0) ? digf_pkg::ST_DONE : digf_pkg::ST_CHECK;
                end
            end
            digf_pkg::ST_CHECK: begin
                n_state = (r_y < digf_pkg::THR_Y) ? digf_pkg::ST_DIV_REC : digf_pkg::ST_DIV_R;
            end
            digf_pkg::ST_DIV_REC:  n_state = digf_pkg::ST_WAIT_REC;
            digf_pkg::ST_WAIT_REC: if (div_done) n_state = digf_pkg::ST_CHECK;
            digf_pkg::ST_DIV_R:    n_state = digf_pkg::ST_WAIT_R;
            digf_pkg::ST_WAIT_R:   if (div_done) n_state = digf_pkg::ST_NORM;
            digf_pkg::ST_NORM:     if (r_y[31]) n_state = digf_pkg::ST_SQ;
            digf_pkg::ST_SQ:       if (r_cnt == 5'd31) n_state = digf_pkg::ST_LN_I;
            digf_pkg::ST_LN_I:     n_state = digf_pkg::ST_LN_F;
            digf_pkg::ST_LN_F:     n_state = digf_pkg::ST_R2;
            digf_pkg::ST_R2:       n_state = digf_pkg::ST_T1;
            digf_pkg::ST_T1:       n_state = digf_pkg::ST_T2;
            digf_pkg::ST_T2:       n_state = digf_pkg::ST_T3;
            digf_pkg::ST_T3:       n_state = digf_pkg::ST_T4;
            digf_pkg::ST_T4:       n_state = digf_pkg::ST_T5;
            digf_pkg::ST_T5:       n_state = digf_pkg::ST_ACC1;
            digf_pkg::ST_ACC1:     n_state = digf_pkg::ST_ACC2;
            digf_pkg::ST_ACC2:     n_state = digf_pkg::ST_ACC3;
            digf_pkg::ST_ACC3:     n_state = digf_pkg::ST_ROUND;
            digf_pkg::ST_ROUND:    n_state = digf_pkg::ST_DONE;
            digf_pkg::ST_DONE:     if (o_out.ready) n_state = digf_pkg::ST_IDLE;
            default:               n_state = digf_pkg::ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand selection
    always_comb begin
        mul_a     = 32'd0;
        mul_b     = 32'd0;
        div_start = 1'b0;
        unique case (r_state)
            digf_pkg::ST_DIV_REC,
            digf_pkg::ST_DIV_R: div_start = 1'b1;
            digf_pkg::ST_SQ: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            digf_pkg::ST_LN_I: begin
                // integer part of log2 is 15 minus the normalising shift count
                mul_a = {28'd0, 4'd15 - r_k};
                mul_b = digf_pkg::LN2_Q32;
            end
            digf_pkg::ST_LN_F: begin
                mul_a = r_frac;
                mul_b = digf_pkg::LN2_Q32;
            end
            digf_pkg::ST_R2: begin
                mul_a = r_r;
                mul_b = r_r;
            end
            digf_pkg::ST_T1: begin
                mul_a = digf_pkg::C252_Q32;
                mul_b = r_r2;
            end
            digf_pkg::ST_T3,
            digf_pkg::ST_T5: begin
                mul_a = r_t;
                mul_b = r_r2;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign i_in.ready        = (r_state == digf_pkg::ST_IDLE);
    assign o_out.valid       = (r_state == digf_pkg::ST_DONE);
    assign o_out.psi_value   = r_psi;
    assign o_out.invalid_arg = r_inv;
    assign o_out.saturated   = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= digf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            digf_pkg::ST_IDLE: begin
                r_y   <= i_in.x_value;
                r_acc <= '0;
                r_psi <= '0;
                r_inv <= 1'b1;
                r_sat <= 1'b0;
            end
            digf_pkg::ST_WAIT_REC: begin
                if (div_done) begin
                    r_acc <= r_acc - $signed({7'd0, div_quot});
                    r_y   <= r_y + digf_pkg::ONE_Y;
                end
            end
            digf_pkg::ST_WAIT_R: begin
                r_r <= div_quot[31:0];
                r_k <= 4'd0;
            end
            digf_pkg::ST_NORM: begin
                // bring the top bit to bit 31, mantissa sits with its top at bit 30
                if (r_y[31]) begin
                    r_m    <= r_y[31:1];
                    r_cnt  <= 5'd0;
                    r_frac <= 32'd0;
                end else begin
                    r_y <= r_y << 1;
                    r_k <= r_k + 4'd1;
                end
            end
            digf_pkg::ST_SQ: begin
                r_cnt  <= r_cnt + 5'd1;
                r_frac <= {r_frac[30:0], prod[61]};
                r_m    <= prod[61] ? prod[61:31] : prod[60:30];
            end
            digf_pkg::ST_LN_I:  r_lnv <= prod[36:0];
            digf_pkg::ST_LN_F:  r_lnv <= r_lnv + {5'd0, prod_rnd};
            digf_pkg::ST_R2:    r_r2  <= prod_rnd;
            digf_pkg::ST_T1:    r_t   <= prod_rnd;
            digf_pkg::ST_T2:    r_t   <= digf_pkg::C120_Q32 - r_t;
            digf_pkg::ST_T3:    r_t   <= prod_rnd;
            digf_pkg::ST_T4:    r_t   <= digf_pkg::C12_Q32 - r_t;
            digf_pkg::ST_T5:    r_t   <= prod_rnd;
            digf_pkg::ST_ACC1:  r_acc <= r_acc + $signed({19'd0, r_lnv});
            digf_pkg::ST_ACC2:  r_acc <= r_acc - $signed({25'd0, r_r[31:1]});
            digf_pkg::ST_ACC3:  r_acc <= r_acc - $signed({24'd0, r_t});
            digf_pkg::ST_ROUND: begin
                // round half away from zero, then clamp to the 48-bit range
                r_inv <= 1'b0;
                if (r_acc[digf_pkg::ACC_W-1]) begin
                    if (q48 > digf_pkg::OUT_MINM) begin
                        r_psi <= $signed(digf_pkg::OUT_MINM);
                        r_sat <= 1'b1;
                    end else begin
                        r_psi <= $signed(48'(-q48));
                        r_sat <= 1'b0;
                    end
                end else begin
                    if (q48 > digf_pkg::OUT_MAX) begin
                        r_psi <= $signed(digf_pkg::OUT_MAX);
                        r_sat <= 1'b1;
                    end else begin
                        r_psi <= $signed(q48);
                        r_sat <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: sim/tb_digamma_fixed_point.sv
// self-checking testbench for the fixed-point digamma block
`timescale 1ns / 1ps

module tb_digamma_fixed_point;

    typedef struct packed {
        logic signed [47:0] psi;
        logic               inv;
        logic               sat;
    } t_psi_res;

    // predictor of psi(x) in q.32 arithmetic, rounded to the output format
    function automatic logic [63:0] recip_q32(logic [63:0] y);
        logic [63:0] num;
        num = 64'd1 << (digf_pkg::QB + digf_pkg::FRAC_BITS);
        return (num + (y >> 1)) / y;
    endfunction

    function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
        logic [63:0] p;
        p = a * b + (64'd1 << (digf_pkg::QB - 1));
        return p >> digf_pkg::QB;
    endfunction

    function automatic logic [63:0] ln_q32(logic [63:0] y);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] ip;
        e = 0;
        frac = 0;
        while (e < 63 && (y >> (e + 1)) != 0) e++;
        if (e > 30) m = y >> (e - 30);
        else m = y << (30 - e);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        ip = 64'(e - digf_pkg::FRAC_BITS);
        return ip * digf_pkg::LN2_Q32
               + ((frac * digf_pkg::LN2_Q32 + (64'd1 << 31)) >> 32);
    endfunction

    function automatic t_psi_res psi_predict(logic [31:0] x);
        t_psi_res          res;
        logic [63:0]       y, sumrec, r, r2, t, lnv, half, mag, q;
        logic signed [63:0] acc;
        int                sh;
        sh = digf_pkg::QB - digf_pkg::FRAC_BITS;
        y = 64'(x);
        sumrec = 0;
        res = '0;
        if (y == 0) begin
            res.inv = 1'b1;
            return res;
        end
        while (y < 64'(digf_pkg::THR_Y)) begin
            sumrec += recip_q32(y);
            y += 64'(digf_pkg::ONE_Y);
        end
        r = recip_q32(y);
        lnv = ln_q32(y);
        half = r >> 1;
        r2 = mul_q32(r, r);
        t = mul_q32(64'(digf_pkg::C252_Q32), r2);
        t = 64'(digf_pkg::C120_Q32) - t;
        t = mul_q32(t, r2);
        t = 64'(digf_pkg::C12_Q32) - t;
        t = mul_q32(t, r2);
        acc = $signed(lnv) - $signed(half) - $signed(t) - $signed(sumrec);
        mag = (acc < 0) ? -acc : acc;
        q = (mag + (64'd1 << (sh - 1))) >> sh;
        if (acc < 0) begin
            if (q > 64'(digf_pkg::OUT_MAX) + 1) begin
                res.psi = digf_pkg::OUT_MINM;
                res.sat = 1'b1;
            end else begin
                res.psi = 48'(-$signed(q));
            end
        end else if (q > 64'(digf_pkg::OUT_MAX)) begin
            res.psi = digf_pkg::OUT_MAX;
            res.sat = 1'b1;
        end else begin
            res.psi = q[47:0];
        end
        return res;
    endfunction

    class psi_scoreboard;
        t_psi_res pending[$];
        int       errors;

        function void note_arg(logic [31:0] x);
            pending = {pending, psi_predict(x)};
        endfunction

        function void check_result(t_psi_res got);
            t_psi_res exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result psi=%0d inv=%0b sat=%0b",
                         $time, got.psi, got.inv, got.sat);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.psi !== exp_r.psi) begin
                $display("%0t: psi expected %0d actual %0d", $time, exp_r.psi, got.psi);
                errors++;
            end
            if (got.inv !== exp_r.inv) begin
                $display("%0t: invalid expected %0b actual %0b", $time, exp_r.inv, got.inv);
                errors++;
            end
            if (got.sat !== exp_r.sat) begin
                $display("%0t: saturated expected %0b actual %0b",
                         $time, exp_r.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 40000;

    logic          i_clk;
    logic          i_rst_n;
    digf_in_if     arg_if();
    digf_out_if    psi_if();
    psi_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            idle_cycles;

    digamma_fixed_point u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (arg_if.sink),
        .o_out  (psi_if.source)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // sample results and count cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n && psi_if.valid && psi_if.ready)
            sb.check_result(t_psi_res'{psi_if.psi_value, psi_if.invalid_arg,
                                       psi_if.saturated});
        if ((arg_if.valid && arg_if.ready) || (psi_if.valid && psi_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** digamma_fixed_point: FAILED **");
            $finish;
        end
    end

    // receiver stalls at random at the falling edge
    always @(negedge i_clk)
        psi_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    // valid drops only while the sender idles, so it is never driven twice in one step
    task automatic send_arg(logic [31:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            arg_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        arg_if.valid   <= 1'b1;
        arg_if.x_value <= x;
        @(posedge i_clk);
        while (!arg_if.ready) @(posedge i_clk);
        sb.note_arg(x);
        @(negedge i_clk);
    endtask

    // tiny, fractional, mid-range (1 to 16) and full-range arguments, plus shifted ones
    function automatic logic [31:0] rand_arg();
        int k;
        k = $urandom_range(99);
        if (k < 5) return 32'($urandom_range(3));
        if (k < 15) return 32'($urandom_range(digf_pkg::ONE_Y));
        if (k < 45) return 32'($urandom_range(digf_pkg::THR_Y + 32'h4_0000, 32'h1_0000));
        if (k < 85) return $urandom;
        return 32'($urandom) >> $urandom_range(31);
    endfunction

    task automatic wait_drained();
        arg_if.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] directed[$];
        sb = new();
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        arg_if.valid = 1'b0;
        arg_if.x_value = '0;
        psi_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero, smallest, fractions, one, the recurrence boundary, largest
        directed = '{32'h0, 32'h1, 32'h2, 32'h8000, 32'hFFFF, 32'h1_0000, 32'h2_0000,
                     32'h1_8000, 32'hB_FFFF, digf_pkg::THR_Y, digf_pkg::THR_Y + 1,
                     32'hD_0000, 32'h10_0000, 32'h100_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (directed[i]) send_arg(directed[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int n = 0; n < 470; n++) begin
                if (n == 200) wait_drained();
                send_arg(rand_arg());
            end
        end

        wait_drained();
        repeat (800) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** digamma_fixed_point: PASSED **");
        else
            $display("** digamma_fixed_point: FAILED **");
        $finish;
    end
endmodule

FILE: filelist.f
design/digf_pkg.sv
design/digf_if.sv
design/digf_div.sv
design/digamma_fixed_point.sv
sim/tb_digamma_fixed_point.sv
